>>> design/ard_pkg.sv
`timescale 1ns / 1ps

package ard_pkg;

    localparam int FREQ_W   = 31;
    localparam int TAB_W    = 4;
    localparam int SYM_W    = 8;
    localparam int FADDR_W  = TAB_W + SYM_W;
    localparam int FDEPTH   = 1 << FADDR_W;
    localparam int NSYM_MAX = 1 << SYM_W;
    localparam int TOT_W    = FREQ_W + SYM_W;

    localparam logic [FREQ_W-1:0] FREQ_MAX  = {FREQ_W{1'b1}};
    // min(2^64-1 div 2^32, 2^30 + 2)
    localparam logic [TOT_W-1:0]  TOT_LIMIT = 39'd1073741826;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_PUSH   = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;
    localparam logic [1:0] REQ_DECODE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TABLE = 2'd1;
    localparam logic [1:0] ST_DRY   = 2'd2;

    localparam logic REG_ADAPTIVE = 1'b0;
    localparam logic REG_SYMBOLS  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_ACC,
        S_CHECK,
        S_V_WAIT,
        S_SRCH,
        S_SRCH_CMP,
        S_LO_GO,
        S_LO_WAIT,
        S_HI_GO,
        S_HI_WAIT,
        S_E1,
        S_E2,
        S_ADAPT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    // q = (a * b - sub) / d
    typedef struct packed {
        logic        start;
        logic        sub;
        logic [32:0] a;
        logic [30:0] b;
        logic [32:0] d;
    } md_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [32:0] q;
    } md_rsp_t;

    typedef struct packed {
        logic code_bit;
        logic dry;
    } bb_stat_t;

endpackage

>>> design/ard_if.sv
`timescale 1ns / 1ps

interface ard_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  table_sel;
    logic [7:0]  symbol_index;
    logic [30:0] freq_value;
    logic [7:0]  byte_value;

    modport source (output valid, req_type, table_sel, symbol_index, freq_value, byte_value,
                    input ready);
    modport sink (input valid, req_type, table_sel, symbol_index, freq_value, byte_value,
                  output ready);
endinterface

interface ard_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       is_end;
    logic [1:0] status;

    modport source (output valid, symbol, is_end, status, input ready);
    modport sink (input valid, symbol, is_end, status, output ready);
endinterface

>>> design/ard_muldiv.sv
`timescale 1ns / 1ps

module ard_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  ard_pkg::md_req_t req,
    output ard_pkg::md_rsp_t rsp
);

    ard_pkg::md_state_t phase_reg, phase_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [30:0] mult_reg, mult_next;
    logic [63:0] acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic        done_reg, done_next;
    logic [33:0] rem_sh;
    logic [33:0] rem_dif;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ard_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        done_next  = 1'b0;
        rem_sh     = {rem_reg, acc_reg[63]};
        rem_dif    = rem_sh - {1'b0, den_reg};
        case (phase_reg)
            ard_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = {31'd0, req.a};
                    mult_next  = req.b;
                    // preload minus sub so the product lands already corrected
                    acc_next   = req.sub ? {64{1'b1}} : 64'd0;
                    cnt_next   = 6'd0;
                    rem_next   = 33'd0;
                    den_next   = req.d;
                    phase_next = ard_pkg::MD_MUL;
                end
            end
            ard_pkg::MD_MUL:
            begin
                if (mult_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[62:0], 1'b0};
                mult_next  = {1'b0, mult_reg[30:1]};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd30)
                begin
                    cnt_next   = 6'd0;
                    phase_next = ard_pkg::MD_DIV;
                end
            end
            ard_pkg::MD_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_dif[32:0];
                    acc_next = {acc_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[32:0];
                    acc_next = {acc_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    phase_next = ard_pkg::MD_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = ard_pkg::MD_IDLE;
            end
        endcase
    end

    assign rsp.busy = (phase_reg != ard_pkg::MD_IDLE);
    assign rsp.done = done_reg;
    assign rsp.q    = acc_reg[32:0];

endmodule

>>> design/ard_bitbuf.sv
`timescale 1ns / 1ps

module ard_bitbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  logic [7:0]        push_byte,
    input  logic              pull_en,
    output ard_pkg::bb_stat_t stat
);

    logic [7:0] buf_mem [16];
    logic [3:0] head_reg, head_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] bl_reg, bl_next;
    logic       empty;
    logic       push_ok;
    logic       pop;
    logic [3:0] bl_cur;
    logic [3:0] bl_dec;
    logic [3:0] wr_idx;

    assign empty   = (bl_reg == 4'd0) && (cnt_reg == 5'd0);
    assign push_ok = push_en && !cnt_reg[4];
    assign bl_cur  = (bl_reg == 4'd0) ? 4'd8 : bl_reg;
    assign bl_dec  = bl_cur - 4'd1;
    assign pop     = pull_en && !empty && (bl_dec == 4'd0);
    assign wr_idx  = head_reg + cnt_reg[3:0];

    assign stat.dry      = empty;
    assign stat.code_bit = empty ? 1'b0 : buf_mem[head_reg][bl_dec[2:0]];

    always_comb
    begin
        head_next = head_reg;
        bl_next   = bl_reg;
        cnt_next  = cnt_reg + {4'd0, push_ok} - {4'd0, pop};
        if (pull_en && !empty)
        begin
            bl_next = bl_dec;
        end
        if (pop)
        begin
            head_next = head_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 4'd0;
            cnt_reg  <= 5'd0;
            bl_reg   <= 4'd0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            bl_reg   <= bl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            buf_mem[wr_idx] <= push_byte;
        end
    end

endmodule

>>> design/arithmetic_range_decoder.sv
`timescale 1ns / 1ps

// channel   dir   handshake        payload
// req_ch    sink  valid / ready    req_type, table_sel, symbol_index, freq_value, byte_value
// res_ch    src   valid / ready    symbol, is_end, status
// apb       cfg   psel / penable   adaptive_mode at 0x0, symbols_in_use at 0x4
//
// load and push items are taken in S_IDLE; a start item then shifts in 32 code bits in S_START
// a decode for n symbols in use consists of:
//   summing the n table entries through the single frequency store read port,
//   three runs of the shared bit-serial multiply/divide unit (31 + 64 steps each),
//   the binary search (S_SRCH then S_SRCH_CMP per step), and the shifted code bits
// after reset the frequency store is cleared, one entry a cycle, all 4096 entries,
//   and no transfer is taken on req_ch meanwhile (configuration writes still land)
// a finished result sits in the output register; the next item is taken while it waits,
//   and a decode only stalls at its end when the previous result has not left

module arithmetic_range_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ard_req_if.sink     req_ch,
    ard_res_if.source   res_ch
);

    // configuration registers
    logic       adaptive_reg;
    logic [8:0] syms_reg;
    logic       cfg_wr;

    // sequencer state
    ard_pkg::state_t state_reg, state_next;
    logic [8:0]  k_reg, k_next;
    logic        rv_reg, rv_next;
    logic [7:0]  ridx_reg, ridx_next;
    logic [3:0]  t_reg, t_next;
    logic [38:0] tot_reg, tot_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic [31:0] code_reg, code_next;
    logic [32:0] span_reg, span_next;
    logic [30:0] v_reg, v_next;
    logic [8:0]  lo_reg, lo_next;
    logic [8:0]  hi_reg, hi_next;
    logic [8:0]  m_reg, m_next;
    logic [31:0] nl_reg, nl_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [11:0] clr_reg, clr_next;
    logic        err_reg, err_next;
    logic        dry_reg, dry_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] sym_reg, sym_next;
    logic       end_reg, end_next;
    logic [1:0] status_reg, status_next;

    // frequency store, 16 tables x 256 symbols
    logic [30:0] freq_mem [4096];
    logic        f_re;
    logic [11:0] f_raddr;
    logic [30:0] f_rdata_reg;
    logic        f_we;
    logic [11:0] f_waddr;
    logic [30:0] f_wdata;

    // prefix sums: entry i holds the cumulative count up to and including symbol i
    logic [30:0] cum_mem [256];
    logic        c_re;
    logic [7:0]  c_raddr;
    logic [30:0] c_rdata_reg;
    logic        c_we;
    logic [7:0]  c_waddr;
    logic [30:0] c_wdata;

    ard_pkg::md_req_t  md_req;
    ard_pkg::md_rsp_t  md_rsp;
    ard_pkg::bb_stat_t bb_stat;
    logic              push_en;
    logic              pull_en;

    // helpers
    logic [8:0]  n_sym;
    logic [8:0]  n_last;
    logic [38:0] tot_sum;
    logic [32:0] span_calc;
    logic [32:0] off_calc;
    logic [9:0]  mid_sum;
    logic [8:0]  mid;
    logic        e1_cond;
    logic        e2_cond;
    logic        out_free;
    logic        take;

    ard_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    ard_bitbuf u_bb (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push_byte (req_ch.byte_value),
        .pull_en   (pull_en),
        .stat      (bb_stat)
    );

    // apb register file, zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == ard_pkg::REG_SYMBOLS) ? {23'd0, syms_reg}
                                                       : {31'd0, adaptive_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adaptive_reg <= 1'b0;
            syms_reg     <= 9'd256;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ard_pkg::REG_ADAPTIVE)
            begin
                adaptive_reg <= pwdata[0];
            end
            else
            begin
                syms_reg <= pwdata[8:0];
            end
        end
    end

    // symbol count clamped to 1..256
    assign n_sym  = (syms_reg == 9'd0) ? 9'd1 : ((syms_reg > 9'd256) ? 9'd256 : syms_reg);
    assign n_last = n_sym - 9'd1;

    assign take     = req_ch.valid && req_ch.ready;
    assign out_free = !out_valid_reg || res_ch.ready;
    assign tot_sum  = tot_reg + {8'd0, f_rdata_reg};

    // code offset into the current range, clamped to it
    assign span_calc = {1'b0, high_reg} - {1'b0, low_reg} + 33'd1;
    assign off_calc  = (code_reg < low_reg) ? 33'd0 :
                       ((code_reg > high_reg) ? (span_calc - 33'd1)
                                              : ({1'b0, code_reg} - {1'b0, low_reg}));

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[9:1];

    // settled msb, then underflow straddle
    assign e1_cond = (low_reg[31] == high_reg[31]) && (cnt_reg <= 6'd32);
    assign e2_cond = low_reg[30] && !high_reg[30] && (cnt_reg <= 6'd32);

    assign req_ch.ready = (state_reg == ard_pkg::S_IDLE);
    assign push_en      = take && (req_ch.req_type == ard_pkg::REQ_PUSH);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        rv_next        = 1'b0;
        ridx_next      = ridx_reg;
        t_next         = t_reg;
        tot_next       = tot_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        code_next      = code_reg;
        span_next      = span_reg;
        v_next         = v_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        m_next         = m_reg;
        nl_next        = nl_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        err_next       = err_reg;
        dry_next       = dry_reg;
        out_valid_next = out_valid_reg && !res_ch.ready;
        sym_next       = sym_reg;
        end_next       = end_reg;
        status_next    = status_reg;
        f_re           = 1'b0;
        f_raddr        = {t_reg, k_reg[7:0]};
        f_we           = 1'b0;
        f_waddr        = {req_ch.table_sel, req_ch.symbol_index};
        f_wdata        = req_ch.freq_value;
        c_re           = 1'b0;
        c_raddr        = 8'd0;
        c_we           = 1'b0;
        c_waddr        = ridx_reg;
        c_wdata        = tot_sum[30:0];
        md_req.start   = 1'b0;
        md_req.sub     = 1'b0;
        md_req.a       = span_reg;
        md_req.b       = c_rdata_reg;
        md_req.d       = tot_reg[32:0];
        pull_en        = 1'b0;

        case (state_reg)
            ard_pkg::S_CLEAR:
            begin
                f_we     = 1'b1;
                f_waddr  = clr_reg;
                f_wdata  = 31'd0;
                clr_next = clr_reg + 12'd1;
                if (clr_reg == 12'hFFF)
                begin
                    state_next = ard_pkg::S_IDLE;
                end
            end
            ard_pkg::S_IDLE:
            begin
                if (take)
                begin
                    case (req_ch.req_type)
                        ard_pkg::REQ_LOAD:
                        begin
                            f_we = 1'b1;
                        end
                        ard_pkg::REQ_START:
                        begin
                            low_next   = 32'd0;
                            high_next  = 32'hFFFF_FFFF;
                            code_next  = 32'd0;
                            cnt_next   = 6'd0;
                            state_next = ard_pkg::S_START;
                        end
                        ard_pkg::REQ_DECODE:
                        begin
                            t_next     = req_ch.table_sel;
                            k_next     = 9'd0;
                            tot_next   = 39'd0;
                            state_next = ard_pkg::S_ACC;
                        end
                        default:
                        begin
                            // push is handled by the byte buffer
                        end
                    endcase
                end
            end
            ard_pkg::S_START:
            begin
                pull_en   = 1'b1;
                code_next = {code_reg[30:0], bb_stat.code_bit};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    state_next = ard_pkg::S_IDLE;
                end
            end
            ard_pkg::S_ACC:
            begin
                // read one entry a cycle, sum as the data comes back
                if (k_reg < n_sym)
                begin
                    f_re      = 1'b1;
                    rv_next   = 1'b1;
                    ridx_next = k_reg[7:0];
                    k_next    = k_reg + 9'd1;
                end
                if (rv_reg)
                begin
                    tot_next = tot_sum;
                    c_we     = 1'b1;
                end
                if (!(k_reg < n_sym) && !rv_reg)
                begin
                    state_next = ard_pkg::S_CHECK;
                end
            end
            ard_pkg::S_CHECK:
            begin
                if ((tot_reg == 39'd0) || (tot_reg > ard_pkg::TOT_LIMIT))
                begin
                    err_next   = 1'b1;
                    state_next = ard_pkg::S_OUT;
                end
                else
                begin
                    // v = ((off + 1) * tot - 1) / span
                    err_next     = 1'b0;
                    dry_next     = 1'b0;
                    span_next    = span_calc;
                    md_req.start = 1'b1;
                    md_req.sub   = 1'b1;
                    md_req.a     = off_calc + 33'd1;
                    md_req.b     = tot_reg[30:0];
                    md_req.d     = span_calc;
                    state_next   = ard_pkg::S_V_WAIT;
                end
            end
            ard_pkg::S_V_WAIT:
            begin
                if (md_rsp.done)
                begin
                    v_next     = md_rsp.q[30:0];
                    lo_next    = 9'd0;
                    hi_next    = n_sym;
                    state_next = ard_pkg::S_SRCH;
                end
            end
            ard_pkg::S_SRCH:
            begin
                c_re = 1'b1;
                if ((hi_reg - lo_reg) > 9'd1)
                begin
                    c_raddr    = 8'(mid - 9'd1);
                    m_next     = mid;
                    state_next = ard_pkg::S_SRCH_CMP;
                end
                else
                begin
                    c_raddr    = 8'(lo_reg - 9'd1);
                    state_next = ard_pkg::S_LO_GO;
                end
            end
            ard_pkg::S_SRCH_CMP:
            begin
                if (c_rdata_reg > v_reg)
                begin
                    hi_next = m_reg;
                end
                else
                begin
                    lo_next = m_reg;
                end
                state_next = ard_pkg::S_SRCH;
            end
            ard_pkg::S_LO_GO:
            begin
                // cumulative count below the symbol is zero for the first one
                md_req.start = 1'b1;
                md_req.b     = (lo_reg == 9'd0) ? 31'd0 : c_rdata_reg;
                state_next   = ard_pkg::S_LO_WAIT;
            end
            ard_pkg::S_LO_WAIT:
            begin
                if (md_rsp.done)
                begin
                    nl_next    = low_reg + md_rsp.q[31:0];
                    c_re       = 1'b1;
                    c_raddr    = lo_reg[7:0];
                    state_next = ard_pkg::S_HI_GO;
                end
            end
            ard_pkg::S_HI_GO:
            begin
                md_req.start = 1'b1;
                state_next   = ard_pkg::S_HI_WAIT;
            end
            ard_pkg::S_HI_WAIT:
            begin
                if (md_rsp.done)
                begin
                    high_next  = low_reg + md_rsp.q[31:0] - 32'd1;
                    low_next   = nl_reg;
                    cnt_next   = 6'd0;
                    state_next = ard_pkg::S_E1;
                end
            end
            ard_pkg::S_E1:
            begin
                if (e1_cond)
                begin
                    pull_en   = 1'b1;
                    dry_next  = dry_reg || bb_stat.dry;
                    code_next = {code_reg[30:0], bb_stat.code_bit};
                    low_next  = {low_reg[30:0], 1'b0};
                    high_next = {high_reg[30:0], 1'b1};
                    cnt_next  = cnt_reg + 6'd1;
                end
                else
                begin
                    cnt_next   = 6'd0;
                    state_next = ard_pkg::S_E2;
                end
            end
            ard_pkg::S_E2:
            begin
                if (e2_cond)
                begin
                    pull_en   = 1'b1;
                    dry_next  = dry_reg || bb_stat.dry;
                    code_next = {code_reg[31], code_reg[29:0], bb_stat.code_bit};
                    low_next  = {!low_reg[30], low_reg[29:0], 1'b0};
                    high_next = {1'b1, high_reg[29:0], 1'b1};
                    cnt_next  = cnt_reg + 6'd1;
                end
                else if (adaptive_reg && (lo_reg != n_last))
                begin
                    f_re       = 1'b1;
                    f_raddr    = {t_reg, lo_reg[7:0]};
                    state_next = ard_pkg::S_ADAPT;
                end
                else
                begin
                    state_next = ard_pkg::S_OUT;
                end
            end
            ard_pkg::S_ADAPT:
            begin
                // saturating count update
                if (f_rdata_reg != ard_pkg::FREQ_MAX)
                begin
                    f_we    = 1'b1;
                    f_waddr = {t_reg, lo_reg[7:0]};
                    f_wdata = f_rdata_reg + 31'd1;
                end
                state_next = ard_pkg::S_OUT;
            end
            ard_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        sym_next    = 8'd0;
                        end_next    = 1'b0;
                        status_next = ard_pkg::ST_TABLE;
                    end
                    else
                    begin
                        sym_next    = lo_reg[7:0];
                        end_next    = (lo_reg == n_last);
                        status_next = dry_reg ? ard_pkg::ST_DRY : ard_pkg::ST_OK;
                    end
                    state_next = ard_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ard_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ard_pkg::S_CLEAR;
            clr_reg       <= 12'd0;
            rv_reg        <= 1'b0;
            low_reg       <= 32'd0;
            high_reg      <= 32'hFFFF_FFFF;
            code_reg      <= 32'd0;
            dry_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rv_reg        <= rv_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            code_reg      <= code_next;
            dry_reg       <= dry_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        ridx_reg   <= ridx_next;
        t_reg      <= t_next;
        tot_reg    <= tot_next;
        span_reg   <= span_next;
        v_reg      <= v_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        m_reg      <= m_next;
        nl_reg     <= nl_next;
        cnt_reg    <= cnt_next;
        sym_reg    <= sym_next;
        end_reg    <= end_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            freq_mem[f_waddr] <= f_wdata;
        end
        if (f_re)
        begin
            f_rdata_reg <= freq_mem[f_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cum_mem[c_waddr] <= c_wdata;
        end
        if (c_re)
        begin
            c_rdata_reg <= cum_mem[c_raddr];
        end
    end

    assign res_ch.valid  = out_valid_reg;
    assign res_ch.symbol = sym_reg;
    assign res_ch.is_end = end_reg;
    assign res_ch.status = status_reg;

`ifndef SYNTH
    // the shared unit is never restarted mid-operation
    a_md_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("multiply/divide started while busy");

    // narrowing never inverts the range
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ard_pkg::S_HI_WAIT && md_rsp.done) |=> (low_reg <= high_reg))
        else $error("range low above range high after narrowing");

    // renormalization leaves the top bits of low and high apart
    a_renorm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ard_pkg::S_E2 && !e2_cond) |-> (low_reg[31] != high_reg[31]))
        else $error("range not renormalized");
`endif

endmodule

>>> tb/ard_decode_checker.sv
`timescale 1ns / 1ps

module ard_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    ard_req_if          req,
    ard_res_if          res,
    output int          fail_count,
    output int          pending,
    output int          decodes_seen,
    output int          table_errors,
    output int          dry_decodes
);

    localparam logic [63:0] STATE_MASK = 64'hFFFF_FFFF;
    localparam logic [63:0] HALF_BIT   = 64'h8000_0000;
    localparam logic [63:0] QUART_BIT  = 64'h4000_0000;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_end;
        logic [1:0] status;
    } sym_result_t;

    logic [ard_pkg::FREQ_W-1:0] freq_mem [0:ard_pkg::FDEPTH-1];
    logic [63:0]       range_lo, range_hi, code_reg;
    logic [7:0]        byte_fifo[$];
    int                bits_left;
    logic              adaptive;
    logic [8:0]        nsym;
    logic              ran_dry;
    sym_result_t       expected_symbols[$];

    function automatic logic pull_bit();
        logic b;
        if (bits_left == 0)
        begin
            if (byte_fifo.size() == 0)
            begin
                ran_dry = 1'b1;
                return 1'b0;
            end
            bits_left = 8;
        end
        bits_left--;
        b = byte_fifo[0][bits_left];
        if (bits_left == 0)
            void'(byte_fifo.pop_front());
        return b;
    endfunction

    function automatic sym_result_t decode_symbol(input logic [3:0] tsel);
        sym_result_t r;
        longint unsigned cum [0:ard_pkg::NSYM_MAX];
        longint unsigned tot, span, off, v, nl, nh;
        int n, k, lo, hi, m;
        r = '{symbol: 8'd0, is_end: 1'b0, status: ard_pkg::ST_TABLE};
        n = (nsym < 1) ? 1 : ((nsym > ard_pkg::NSYM_MAX) ? ard_pkg::NSYM_MAX : int'(nsym));
        cum[0] = 0;
        for (k = 0; k < n; k++)
            cum[k+1] = cum[k] + freq_mem[{tsel, k[7:0]}];
        tot = cum[n];
        if (tot == 0 || tot > ard_pkg::TOT_LIMIT)
            return r;
        ran_dry = 1'b0;
        span = range_hi - range_lo + 1;
        if (code_reg < range_lo)      off = 0;
        else if (code_reg > range_hi) off = span - 1;
        else                          off = code_reg - range_lo;
        v = ((off + 1) * tot - 1) / span;
        lo = 0;
        hi = n;
        while (hi - lo > 1)
        begin
            m = (lo + hi) >> 1;
            if (cum[m] > v) hi = m;
            else            lo = m;
        end
        nl = range_lo + cum[lo] * span / tot;
        nh = range_lo + cum[lo+1] * span / tot - 1;
        range_lo = nl;
        range_hi = nh;
        for (k = 0; k <= 32 && ((range_lo ^ range_hi) & HALF_BIT) == 0; k++)
        begin
            code_reg = ((code_reg << 1) & STATE_MASK) | 64'(pull_bit());
            range_lo = (range_lo << 1) & STATE_MASK;
            range_hi = ((range_hi << 1) & STATE_MASK) | 64'd1;
        end
        for (k = 0; k <= 32 && (range_lo & ~range_hi & QUART_BIT) != 0; k++)
        begin
            code_reg = (code_reg & HALF_BIT) | ((code_reg << 1) & (STATE_MASK >> 1))
                       | 64'(pull_bit());
            range_lo = ((range_lo << 1) ^ HALF_BIT) & STATE_MASK;
            range_hi = (((range_hi ^ HALF_BIT) << 1) | HALF_BIT | 64'd1) & STATE_MASK;
        end
        r.symbol = lo[7:0];
        r.is_end = (lo == n - 1);
        r.status = ran_dry ? ard_pkg::ST_DRY : ard_pkg::ST_OK;
        if (adaptive && lo != n - 1 && freq_mem[{tsel, lo[7:0]}] < ard_pkg::FREQ_MAX)
            freq_mem[{tsel, lo[7:0]}]++;
        return r;
    endfunction

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        decodes_seen = 0;
        table_errors = 0;
        dry_decodes  = 0;
        for (int i = 0; i < ard_pkg::FDEPTH; i++)
            freq_mem[i] = '0;
        range_lo  = 0;
        range_hi  = STATE_MASK;
        code_reg  = 0;
        bits_left = 0;
        adaptive  = 1'b0;
        nsym      = 9'd256;
    end

    always @(posedge clk)
    begin
        sym_result_t got, want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == ard_pkg::REG_SYMBOLS) nsym = pwdata[8:0];
                else                                  adaptive = pwdata[0];
            end
            // results first: a result leaving now belongs to an earlier decode
            if (res.valid && res.ready)
            begin
                got = '{symbol: res.symbol, is_end: res.is_end, status: res.status};
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    ard_pkg::REQ_LOAD:
                        freq_mem[{req.table_sel, req.symbol_index}] = req.freq_value;
                    ard_pkg::REQ_PUSH:
                        if (byte_fifo.size() < 16)
                            byte_fifo.insert(byte_fifo.size(), req.byte_value);
                    ard_pkg::REQ_START:
                    begin
                        range_lo = 0;
                        range_hi = STATE_MASK;
                        code_reg = 0;
                        for (int k = 0; k < 32; k++)
                            code_reg = ((code_reg << 1) & STATE_MASK) | 64'(pull_bit());
                    end
                    default:
                    begin
                        want = decode_symbol(req.table_sel);
                        expected_symbols.insert(expected_symbols.size(), want);
                        decodes_seen++;
                        if (want.status == ard_pkg::ST_TABLE) table_errors++;
                        if (want.status == ard_pkg::ST_DRY)   dry_decodes++;
                    end
                endcase
            end
            pending = expected_symbols.size();
        end
    end

endmodule

>>> tb/arithmetic_range_decoder_test.sv
`timescale 1ns / 1ps

module arithmetic_range_decoder_test;

    // cycles with no transfer before the run is called hung; covers the clear pass
    localparam int IDLE_LIMIT = 20000;
    // quiet cycles after the last result: a start item may still be running
    localparam int SETTLE = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ard_req_if req_ch();
    ard_res_if res_ch();

    int fail_count, pending, decodes_seen, table_errors, dry_decodes;
    int items_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    logic hold_go = 1'b0;
    logic [8:0] nsym_now = 9'd256;

    arithmetic_range_decoder dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .req_ch(req_ch), .res_ch(res_ch)
    );

    ard_decode_checker chk (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .req(req_ch), .res(res_ch),
        .fail_count, .pending, .decodes_seen, .table_errors, .dry_decodes
    );

    always #2 clk = ~clk;

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.req_type     = ard_pkg::REQ_LOAD;
        req_ch.table_sel    = '0;
        req_ch.symbol_index = '0;
        req_ch.freq_value   = '0;
        req_ch.byte_value   = '0;
        res_ch.ready        = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                res_ch.ready <= 1'b0;
                repeat (1500) @(posedge clk);
                hold_go = 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: count cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one transfer on req_ch, with a random idle gap in front;
    // ready is looked at mid-cycle, so the next rising edge is the accepting one
    task automatic send(input logic [1:0] kind, input logic [3:0] tsel,
                        input logic [7:0] sidx, input logic [30:0] fval,
                        input logic [7:0] bval);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.table_sel    <= tsel;
        req_ch.symbol_index <= sidx;
        req_ch.freq_value   <= fval;
        req_ch.byte_value   <= bval;
        @(negedge clk);
        while (!req_ch.ready) @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // stop offering items and wait for every result, then let a start finish
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic adapt, input logic [8:0] nsym);
        drain();
        reg_write(ard_pkg::REG_ADAPTIVE, {31'd0, adapt});
        reg_write(ard_pkg::REG_SYMBOLS, {23'd0, nsym});
        nsym_now = nsym;
    endtask

    // random frequency: mostly small, now and then zero or very large
    function automatic logic [30:0] rand_freq();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)  return 31'd0;
        if (pick < 16) return 31'($urandom_range(0, 32'h4000_0000));
        return 31'($urandom_range(1, 300));
    endfunction

    // well-formed sessions: fill a table, queue bytes, start, decode a run;
    // a slice of the items are random noise
    task automatic random_phase(input int count);
        int stop_at, k, nload, npush, ndec;
        logic [3:0] tsel;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 10)
            begin
                send(2'($urandom_range(3)), 4'($urandom), 8'($urandom),
                     31'($urandom_range(0, 32'h4000_0000)), 8'($urandom));
                continue;
            end
            tsel  = 4'($urandom);
            nload = $urandom_range(1, 6);
            for (k = 0; k < nload; k++)
                send(ard_pkg::REQ_LOAD, tsel,
                     ($urandom_range(9) < 8) ? 8'($urandom_range(0, nsym_now - 1))
                                             : 8'($urandom),
                     rand_freq(), 8'($urandom));
            npush = $urandom_range(2, 12);
            for (k = 0; k < npush; k++)
                send(ard_pkg::REQ_PUSH, 4'($urandom), 8'($urandom), 31'($urandom),
                     8'($urandom));
            if ($urandom_range(9) < 7)
                send(ard_pkg::REQ_START, 4'($urandom), 8'($urandom), 31'($urandom),
                     8'($urandom));
            ndec = $urandom_range(1, 8);
            for (k = 0; k < ndec; k++)
                send(ard_pkg::REQ_DECODE, ($urandom_range(9) < 8) ? tsel : 4'($urandom),
                     8'($urandom), 31'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        configure(1'b0, 9'd256);

        // directed: field extremes, terminator, table errors, buffer running dry
        send(ard_pkg::REQ_LOAD, 4'd0, 8'd0, 31'd5, 8'd0);
        send(ard_pkg::REQ_LOAD, 4'd0, 8'd255, 31'd3, 8'd0);
        send(ard_pkg::REQ_LOAD, 4'd0, 8'd128, 31'd2, 8'd0);
        send(ard_pkg::REQ_PUSH, 4'd0, 8'd0, 31'd0, 8'hFF);
        send(ard_pkg::REQ_PUSH, 4'd0, 8'd0, 31'd0, 8'h00);
        send(ard_pkg::REQ_PUSH, 4'd0, 8'd0, 31'd0, 8'hA5);
        send(ard_pkg::REQ_PUSH, 4'd0, 8'd0, 31'd0, 8'h5A);
        send(ard_pkg::REQ_START, 4'd0, 8'd0, 31'd0, 8'd0);
        send(ard_pkg::REQ_DECODE, 4'd0, 8'd0, 31'd0, 8'd0);
        send(ard_pkg::REQ_DECODE, 4'd0, 8'd0, 31'd0, 8'd0);   // bytes gone: zeros shifted in
        send(ard_pkg::REQ_DECODE, 4'd1, 8'd0, 31'd0, 8'd0);   // empty table
        // total exactly at the limit
        send(ard_pkg::REQ_LOAD, 4'd2, 8'd0, 31'h4000_0000, 8'd0);
        send(ard_pkg::REQ_LOAD, 4'd2, 8'd1, 31'd2, 8'd0);
        send(ard_pkg::REQ_DECODE, 4'd2, 8'd0, 31'd0, 8'd0);
        // one above the limit
        send(ard_pkg::REQ_LOAD, 4'd2, 8'd2, 31'd1, 8'd0);
        send(ard_pkg::REQ_DECODE, 4'd2, 8'd0, 31'd0, 8'd0);
        send(ard_pkg::REQ_LOAD, 4'd15, 8'd170, 31'h2AAA_AAAA, 8'd0);
        send(ard_pkg::REQ_LOAD, 4'd15, 8'd85, 31'h1555_5555, 8'd0);
        send(ard_pkg::REQ_PUSH, 4'd0, 8'd0, 31'd0, 8'h80);
        send(ard_pkg::REQ_START, 4'd0, 8'd0, 31'd0, 8'd0);
        send(ard_pkg::REQ_DECODE, 4'd15, 8'd0, 31'd0, 8'd0);
        send(ard_pkg::REQ_LOAD, 4'd0, 8'd0, 31'd0, 8'd0);
        send(ard_pkg::REQ_DECODE, 4'd0, 8'd0, 31'd0, 8'd0);

        // sender mostly busy, receiver stalls often; long receiver hold-off midway
        gap_pct   = 6;
        stall_pct = 47;
        configure(1'b1, 9'd8);
        random_phase(150);
        hold_go = 1'b1;
        random_phase(40);
        random_phase(150);

        // single symbol: every decode that finds a valid table hits the terminator
        configure(1'b0, 9'd1);
        random_phase(80);

        // the other way round, with a pause for all results
        gap_pct   = 47;
        stall_pct = 6;
        configure(1'b1, 9'd3);
        random_phase(150);
        drain();
        random_phase(100);

        // no idling on either side, full alphabet first, then 16 symbols
        gap_pct   = 0;
        stall_pct = 0;
        configure(1'b1, 9'd256);
        random_phase(80);
        configure(1'b0, 9'd16);
        random_phase(350);

        drain();
        $display("run covered %0d items and %0d decodes", items_sent, decodes_seen);
        $display("table errors %0d, decodes with dry buffer %0d", table_errors, dry_decodes);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
